FILE: src/b2da_pkg.sv
// ----------------------------------------------------------------------------
// b2da_pkg: shared types and constants for the binary to decimal ASCII block
// Digit count, field widths, BCD cell control word and sequencer states.
// ----------------------------------------------------------------------------
package b2da_pkg;

	localparam int VALUE_W  = 16;
	localparam int CHAR_W   = 6;
	localparam int IDX_W    = 3;
	localparam int DIGITS   = 5;
	localparam int BCD_W    = 4;
	localparam int CNT_W    = $clog2(VALUE_W);

	localparam logic [CHAR_W-1:0] ASCII_ZERO  = 6'd48;
	localparam logic [BCD_W-1:0]  BCD_ADJ_MIN = 4'd5;
	localparam logic [BCD_W-1:0]  BCD_ADJ     = 4'd3;
	localparam logic [BCD_W-1:0]  BCD_MAX     = 4'd9;
	localparam logic [BCD_W-1:0]  BCD_TOP_MAX = 4'd6;
	localparam logic [IDX_W-1:0]  LEAD_NONE   = 3'd4;

	typedef logic [BCD_W-1:0] bcd_t;

	// control word from the sequencer to the digit cells and output stage
	typedef struct packed {
		logic clear;
		logic shift;
		logic load_out;
	} b2da_ctl_t;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_RUN  = 3'b010,
		ST_DONE = 3'b100
	} b2da_state_t;

endpackage

FILE: src/b2da_in_if.sv
// ----------------------------------------------------------------------------
// b2da_in_if: input channel of the binary to decimal ASCII block
// Valid/ready handshake carrying one 16-bit binary value per word.
// ----------------------------------------------------------------------------
interface b2da_in_if;
	import b2da_pkg::*;

	logic               valid;
	logic               ready;
	logic [VALUE_W-1:0] value;

	modport source (output valid, output value, input ready);
	modport sink   (input valid, input value, output ready);

endinterface

FILE: src/b2da_out_if.sv
// ----------------------------------------------------------------------------
// b2da_out_if: result channel of the binary to decimal ASCII block
// Valid/ready handshake carrying five ASCII digits and the lead index per word.
// ----------------------------------------------------------------------------
interface b2da_out_if;
	import b2da_pkg::*;

	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] ten_thousands_char;
	logic [CHAR_W-1:0] thousands_char;
	logic [CHAR_W-1:0] hundreds_char;
	logic [CHAR_W-1:0] tens_char;
	logic [CHAR_W-1:0] ones_char;
	logic [IDX_W-1:0]  first_significant;

	modport source (output valid, output ten_thousands_char, output thousands_char,
		output hundreds_char, output tens_char, output ones_char,
		output first_significant, input ready);
	modport sink (input valid, input ten_thousands_char, input thousands_char,
		input hundreds_char, input tens_char, input ones_char,
		input first_significant, output ready);

endinterface

FILE: src/b2da_cell.sv
// ----------------------------------------------------------------------------
// b2da_cell: one BCD digit of the shift-and-add-3 chain
// Adjust the held digit by 3 when it is 5 or more, then shift one bit in
// from the lower neighbor and hand the carried-out bit to the upper one.
// ----------------------------------------------------------------------------
module b2da_cell import b2da_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  b2da_ctl_t ctl,
	input  logic      shift_in,
	output logic      shift_out,
	output bcd_t      digit
);

	bcd_t digit_q;
	bcd_t adj;

	always_comb begin
		adj = (digit_q >= BCD_ADJ_MIN) ? bcd_t'(digit_q + BCD_ADJ) : digit_q;
	end

	assign shift_out = adj[BCD_W-1];
	assign digit     = digit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digit_q <= '0;
		end else if (ctl.clear) begin
			digit_q <= '0;
		end else if (ctl.shift) begin
			digit_q <= {adj[BCD_W-2:0], shift_in};
		end
	end

endmodule

FILE: src/b2da_seq.sv
// ----------------------------------------------------------------------------
// b2da_seq: sequencer of the digit chain
// Take a value, feed all its bits MSB first into the chain,
// then release the digits to the output register once it is free.
// ----------------------------------------------------------------------------
module b2da_seq import b2da_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic [VALUE_W-1:0] value,
	input  logic               out_free,
	output logic               in_ready,
	output logic               serial_bit,
	output b2da_ctl_t          ctl
);

	b2da_state_t        state_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [VALUE_W-1:0] bits_q;
	logic               accept;
	logic               last_bit;

	assign in_ready   = (state_q == ST_IDLE);
	assign accept     = in_ready && in_valid;
	assign last_bit   = (cnt_q == CNT_W'(VALUE_W - 1));
	assign serial_bit = bits_q[VALUE_W-1];

	always_comb begin
		ctl.clear    = accept;
		ctl.shift    = (state_q == ST_RUN);
		ctl.load_out = (state_q == ST_DONE) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					if (accept) begin
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					cnt_q <= cnt_q + 1'b1;
					if (last_bit) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload shift register: load on accept, advance MSB first while running
	always_ff @(posedge clk) begin
		if (accept) begin
			bits_q <= value;
		end else if (ctl.shift) begin
			bits_q <= {bits_q[VALUE_W-2:0], 1'b0};
		end
	end

endmodule

FILE: src/binary_to_decimal_ascii.sv
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii: 16-bit unsigned value to five ASCII decimal digits
// Operation: each accepted value is shifted bit by bit through the digit
//   chain, then the digits are loaded into the output register once it is free.
// Throughput: no new word is taken while the chain is shifting; the next word is
//   taken once the result enters the output register, even while it waits to be taken.
// Reset: arst_n clears the sequencer, the digit cells and the output valid.
// ----------------------------------------------------------------------------
module binary_to_decimal_ascii import b2da_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	b2da_in_if.sink           din,
	b2da_out_if.source        dout
);

	// Digit chain: five BCD cells, index 0 is ten-thousands, 4 is ones.
	// carry[k+1] shifts into cell k, cell k shifts out on carry[k]; the value
	// enters at the ones cell. carry[0] falls off the top and is zero while the chain shifts.
	b2da_ctl_t            ctl;
	logic                 serial_bit;
	logic [DIGITS:0]      carry;
	bcd_t [DIGITS-1:0]    digit;
	logic                 out_valid_q;
	logic                 out_free;
	logic [IDX_W-1:0]     lead;

	assign out_free = !out_valid_q || dout.ready;

	b2da_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (din.valid),
		.value      (din.value),
		.out_free   (out_free),
		.in_ready   (din.ready),
		.serial_bit (serial_bit),
		.ctl        (ctl)
	);

	assign carry[DIGITS] = serial_bit;

	for (genvar k = 0; k < DIGITS; k++) begin : g_cell
		b2da_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.shift_in  (carry[k+1]),
			.shift_out (carry[k]),
			.digit     (digit[k])
		);
	end

	// lead index: first nonzero among the upper four digits, else four
	always_comb begin
		lead = LEAD_NONE;
		for (int k = DIGITS - 2; k >= 0; k--) begin
			if (digit[k] != '0) begin
				lead = IDX_W'(k);
			end
		end
	end

	// output register: hold until taken, load when the chain is done
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.load_out) begin
			out_valid_q <= 1'b1;
		end else if (dout.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load_out) begin
			dout.ten_thousands_char <= ASCII_ZERO + CHAR_W'(digit[0]);
			dout.thousands_char     <= ASCII_ZERO + CHAR_W'(digit[1]);
			dout.hundreds_char      <= ASCII_ZERO + CHAR_W'(digit[2]);
			dout.tens_char          <= ASCII_ZERO + CHAR_W'(digit[3]);
			dout.ones_char          <= ASCII_ZERO + CHAR_W'(digit[4]);
			dout.first_significant  <= lead;
		end
	end

	assign dout.valid = out_valid_q;

	// ------------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------------

	// a 16-bit value never carries out of the ten-thousands cell
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.shift |-> !carry[0])
		else $error("carry out of ten-thousands cell");

	// an accepted word starts shifting in the next cycle
	a_accept_runs: assert property (@(posedge clk) disable iff (!arst_n)
		(din.valid && din.ready) |=> ctl.shift)
		else $error("chain did not start after accept");

	// every digit is valid BCD when it goes to the output register
	a_bcd_valid: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.load_out |-> (digit[0] <= BCD_TOP_MAX) && (digit[1] <= BCD_MAX)
			&& (digit[2] <= BCD_MAX) && (digit[3] <= BCD_MAX) && (digit[4] <= BCD_MAX))
		else $error("digit out of BCD range at output load");

	// no new word is taken while the chain is shifting
	a_busy_not_ready: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.shift |-> !din.ready)
		else $error("input ready while chain is busy");

	// a load always shows up as a valid result
	a_load_valid: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.load_out |=> dout.valid)
		else $error("output load did not raise valid");

endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for binary_to_decimal_ascii
// Sends 16-bit values over the input channel and checks every result word.
// Each word is checked against a digit-by-digit place-value split of the
// accepted value: five ASCII digits and the lead index. Both channel ends
// idle at random in several handshake phases.
// ----------------------------------------------------------------------------
module tb;
	import b2da_pkg::*;

	localparam int CLK_HALF     = 4;
	localparam int CYCLE_LIMIT  = 1000000;
	localparam int TAIL_CYCLES  = 40;
	localparam int PHASES       = 4;
	localparam int ITEMS_PHASE  = 400;

	// One result word: five ASCII digits and the first significant index.
	typedef struct packed {
		logic [CHAR_W-1:0] ten_thousands_char;
		logic [CHAR_W-1:0] thousands_char;
		logic [CHAR_W-1:0] hundreds_char;
		logic [CHAR_W-1:0] tens_char;
		logic [CHAR_W-1:0] ones_char;
		logic [IDX_W-1:0]  first_significant;
	} decimal_chars_t;

	// Predicts the decimal digits of every accepted value and checks result
	// words against them in order.
	class ascii_digit_checker;
		decimal_chars_t pending_chars[$];
		int             errors;
		int             checked;
		int             lead_seen[DIGITS];

		function new();
			errors  = 0;
			checked = 0;
			foreach (lead_seen[i]) lead_seen[i] = 0;
		endfunction

		// Split by place value; the lead index only looks at the top four digits.
		function decimal_chars_t decimal_chars_of(logic [VALUE_W-1:0] v);
			int unsigned    place[DIGITS] = '{10000, 1000, 100, 10, 1};
			int unsigned    rest;
			int unsigned    digit;
			logic [CHAR_W-1:0] chars[DIGITS];
			decimal_chars_t r;
			rest = v;
			r.first_significant = LEAD_NONE;
			for (int k = 0; k < DIGITS; k++) begin
				digit = rest / place[k];
				rest  = rest - digit * place[k];
				if (r.first_significant == LEAD_NONE && digit != 0 && k < DIGITS - 1)
					r.first_significant = IDX_W'(k);
				chars[k] = CHAR_W'(digit) + ASCII_ZERO;
			end
			r.ten_thousands_char = chars[0];
			r.thousands_char     = chars[1];
			r.hundreds_char      = chars[2];
			r.tens_char          = chars[3];
			r.ones_char          = chars[4];
			return r;
		endfunction

		function void note_value(logic [VALUE_W-1:0] v);
			pending_chars.push_back(decimal_chars_of(v));
		endfunction

		function void compare_field(string name, int unsigned exp, int unsigned act);
			if (exp != act) begin
				$error("%s mismatch: expected %0d, got %0d", name, exp, act);
				errors++;
			end
		endfunction

		function void check_chars(decimal_chars_t got);
			decimal_chars_t exp;
			if (pending_chars.size() == 0) begin
				$error("result word with no value pending");
				errors++;
				return;
			end
			exp = pending_chars.pop_front();
			checked++;
			if (got.first_significant < DIGITS) lead_seen[got.first_significant]++;
			compare_field("ten_thousands_char", exp.ten_thousands_char,
				got.ten_thousands_char);
			compare_field("thousands_char", exp.thousands_char, got.thousands_char);
			compare_field("hundreds_char", exp.hundreds_char, got.hundreds_char);
			compare_field("tens_char", exp.tens_char, got.tens_char);
			compare_field("ones_char", exp.ones_char, got.ones_char);
			compare_field("first_significant", exp.first_significant,
				got.first_significant);
		endfunction

		function int pending();
			return pending_chars.size();
		endfunction
	endclass

	bit          clk;
	logic        arst_n;
	int          src_idle_pct;
	int          sink_stall_pct;
	int          cycle_count;
	int          values_sent;

	// Idle percentages per phase: none, sender only, receiver only, both.
	int          src_idle_of[PHASES]   = '{0, 52, 0, 36};
	int          sink_stall_of[PHASES] = '{0, 0, 52, 36};

	ascii_digit_checker board = new();

	b2da_in_if  din();
	b2da_out_if dout();

	binary_to_decimal_ascii dut (
		.clk    (clk),
		.arst_n (arst_n),
		.din    (din),
		.dout   (dout)
	);

	initial begin
		forever #CLK_HALF clk = ~clk;
	end

	// Watchdog: give up well beyond the slowest legal run.
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Verification failed");
		$finish;
	end

	// Receiver side: decide ready for the next edge on every falling edge.
	always @(negedge clk) begin
		dout.ready = ($urandom_range(0, 99) >= sink_stall_pct);
	end

	// Monitor both channels at the rising edge, before the block updates.
	// Note the accepted value first so a same-edge result still finds it.
	always @(posedge clk) begin
		decimal_chars_t got;
		if (arst_n) begin
			if (din.valid && din.ready)
				board.note_value(din.value);
			if (dout.valid && dout.ready) begin
				got.ten_thousands_char = dout.ten_thousands_char;
				got.thousands_char     = dout.thousands_char;
				got.hundreds_char      = dout.hundreds_char;
				got.tens_char          = dout.tens_char;
				got.ones_char          = dout.ones_char;
				got.first_significant  = dout.first_significant;
				board.check_chars(got);
			end
		end
	end

	// Present one word, idling first as the current phase asks; hold it
	// until the block takes it. Returns on the falling edge after accept.
	task automatic send_value(input logic [VALUE_W-1:0] v);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			din.valid = 1'b0;
			din.value = VALUE_W'($urandom);
			@(negedge clk);
		end
		din.valid = 1'b1;
		din.value = v;
		do @(posedge clk); while (!din.ready);
		@(negedge clk);
		values_sent++;
	endtask

	// Spread random values over every digit count so each lead index shows
	// up often; the rest are plain uniform 16-bit values.
	function automatic logic [VALUE_W-1:0] random_value();
		case ($urandom_range(0, 5))
			0: return VALUE_W'($urandom_range(0, 9));
			1: return VALUE_W'($urandom_range(10, 99));
			2: return VALUE_W'($urandom_range(100, 999));
			3: return VALUE_W'($urandom_range(1000, 9999));
			4: return VALUE_W'($urandom_range(10000, 65535));
			default: return VALUE_W'($urandom);
		endcase
	endfunction

	initial begin
		// Directed values: zero, full scale, every digit-count boundary, a
		// value whose only nonzero digit is the ones digit, and bit patterns.
		logic [VALUE_W-1:0] directed[] = '{
			16'd0, 16'd65535, 16'd1, 16'd9, 16'd10, 16'd99, 16'd100, 16'd999,
			16'd1000, 16'd9999, 16'd10000, 16'd59999, 16'd60000, 16'd65534,
			16'd12345, 16'd54321, 16'd20000, 16'd40000, 16'd900, 16'd5,
			16'h8000, 16'h5555, 16'hAAAA, 16'd909, 16'd30303
		};

		arst_n         = 1'b0;
		din.valid      = 1'b0;
		din.value      = '0;
		src_idle_pct   = 0;
		sink_stall_pct = 0;
		values_sent    = 0;

		// Hold reset, then release it on a falling edge.
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (directed[i]) send_value(directed[i]);

		for (int p = 0; p < PHASES; p++) begin
			src_idle_pct   = src_idle_of[p];
			sink_stall_pct = sink_stall_of[p];
			for (int n = 0; n < ITEMS_PHASE; n++) send_value(random_value());
		end
		din.valid = 1'b0;

		// Drain: wait for every pending word, then let the pipeline settle.
		while (board.pending() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Sent %0d values, checked %0d result words across %0d handshake phases.",
			values_sent, board.checked, PHASES);
		$display("Lead index counts 0..4: %0d %0d %0d %0d %0d",
			board.lead_seen[0], board.lead_seen[1], board.lead_seen[2],
			board.lead_seen[3], board.lead_seen[4]);
		if (board.errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
